// ----- rtl/core/lifegen_pkg.sv -----
`timescale 1ns / 1ps

package lifegen_pkg;

    localparam int CMD_W   = 2;
    localparam int COORD_W = 6;
    localparam int SIZE_W  = 7;
    localparam int NBR_W   = 4;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

    // register index is paddr bit 2
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               cell_value;
    } in_item_t;

    typedef struct packed {
        logic               cell_state;
        logic [CMD_W-1:0]   completed_command;
    } out_item_t;

    typedef struct packed {
        logic first_col;
        logic last_col;
    } cell_edge_t;

endpackage

// ----- rtl/core/lifegen_cell_unit.sv -----
`timescale 1ns / 1ps

module lifegen_cell_unit #(
    parameter int MAX_COLUMNS = lifegen_pkg::DEF_MAX_COLUMNS
) (
    input  logic [MAX_COLUMNS-1:0]         above,
    input  logic [MAX_COLUMNS-1:0]         center,
    input  logic [MAX_COLUMNS-1:0]         below,
    input  logic [$clog2(MAX_COLUMNS)-1:0] col,
    input  lifegen_pkg::cell_edge_t        edges,
    output logic                           alive
);
    import lifegen_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);

    logic [COL_W-1:0] idx_l;
    logic [COL_W-1:0] idx_r;
    logic             al, ac, ar, cl, cc, cr, bl, bc, br;
    logic [NBR_W-1:0] count;

    assign idx_l = col - COL_W'(1);
    assign idx_r = col + COL_W'(1);

    // neighbours beyond the left or right edge of the window count as dead
    assign al = edges.first_col ? 1'b0 : above[idx_l];
    assign cl = edges.first_col ? 1'b0 : center[idx_l];
    assign bl = edges.first_col ? 1'b0 : below[idx_l];
    assign ar = edges.last_col  ? 1'b0 : above[idx_r];
    assign cr = edges.last_col  ? 1'b0 : center[idx_r];
    assign br = edges.last_col  ? 1'b0 : below[idx_r];
    assign ac = above[col];
    assign cc = center[col];
    assign bc = below[col];

    assign count = NBR_W'(al) + NBR_W'(ac) + NBR_W'(ar) + NBR_W'(cl)
                 + NBR_W'(cr) + NBR_W'(bl) + NBR_W'(bc) + NBR_W'(br);

    assign alive = (count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && cc);

endmodule

// ----- rtl/core/life_automaton_generation_step_core.sv -----
`timescale 1ns / 1ps

// Conway life grid (B3/S23) with write-cell, read-cell and generation commands.
// An item is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with strobe high and cannot be held off. A
// write or read inside the window passes through the access state with busy
// high and strobes as the block returns to idle; a write or read outside the
// window, a generation on an empty window and the unused command code strobe
// in the cycle after acceptance without raising busy. A generation keeps busy
// high for the rows x cols window in use, through its prime, fetch, cell and
// write-back states: a single neighbour-count unit evaluates one cell per cycle
// from three row registers, and each row is read once and written back once on
// the row-wide grid memory. After reset the block clears all MAX_ROWS rows one
// row per cycle with busy high; the size registers can be written meanwhile.
module life_automaton_generation_step_core #(
    parameter int MAX_COLUMNS = lifegen_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = lifegen_pkg::DEF_MAX_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  lifegen_pkg::in_item_t            item,
    output logic                             strobe,
    output lifegen_pkg::out_item_t           result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lifegen_pkg::ADDR_W-1:0]   paddr,
    input  logic [lifegen_pkg::DATA_W-1:0]   pwdata,
    output logic [lifegen_pkg::DATA_W-1:0]   prdata,
    output logic                             pready
);
    import lifegen_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CNT_CW = $clog2(MAX_COLUMNS + 1);
    localparam int CNT_RW = $clog2(MAX_ROWS + 1);
    localparam int CMP_CW = (CNT_CW > SIZE_W) ? CNT_CW : SIZE_W;
    localparam int CMP_RW = (CNT_RW > SIZE_W) ? CNT_RW : SIZE_W;
    localparam int RXW    = CNT_RW + 1;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_ACCESS = 7'b0000100,
        ST_PRIME  = 7'b0001000,
        ST_FETCH  = 7'b0010000,
        ST_CELL   = 7'b0100000,
        ST_WB     = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [SIZE_W-1:0]    width_reg, height_reg;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [COL_W-1:0]     col_idx_reg, col_idx_next;
    logic [ROW_W-1:0]     row_idx_reg, row_idx_next;
    logic                 val_reg, val_next;
    logic [ROW_W-1:0]     gen_row_reg, gen_row_next;
    logic [COL_W-1:0]     col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [MAX_COLUMNS-1:0] above_reg, above_next;
    logic [MAX_COLUMNS-1:0] cur_reg, cur_next;
    logic [MAX_COLUMNS-1:0] below_reg, below_next;
    logic [MAX_COLUMNS-1:0] new_reg, new_next;
    logic [MAX_COLUMNS-1:0] rd_data_reg;
    logic                 strobe_reg, strobe_next;
    out_item_t            result_reg, result_next;

    logic [MAX_COLUMNS-1:0] grid_mem [MAX_ROWS];
    logic                 rd_en, wr_en;
    logic [ROW_W-1:0]     rd_addr, wr_addr;
    logic [MAX_COLUMNS-1:0] wr_data;

    logic [CNT_CW-1:0]    cols_used;
    logic [CNT_RW-1:0]    rows_used;
    logic                 window_empty;
    logic                 item_inside;
    logic                 accept;
    logic                 cfg_write;
    logic                 below_ok, below2_ok;
    logic                 cell_alive;
    cell_edge_t           edges;

    // sizes above the grid dimensions saturate
    always_comb
    begin
        if (CMP_CW'(width_reg) > CMP_CW'(MAX_COLUMNS))
            cols_used = CNT_CW'(MAX_COLUMNS);
        else
            cols_used = CNT_CW'(width_reg);
        if (CMP_RW'(height_reg) > CMP_RW'(MAX_ROWS))
            rows_used = CNT_RW'(MAX_ROWS);
        else
            rows_used = CNT_RW'(height_reg);
    end

    assign window_empty = (cols_used == '0) || (rows_used == '0);
    assign item_inside  = (CMP_CW'(item.column) < CMP_CW'(cols_used))
                       && (CMP_RW'(item.row) < CMP_RW'(rows_used));
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign below_ok  = (RXW'(gen_row_reg) + RXW'(1)) < RXW'(rows_used);
    assign below2_ok = (RXW'(gen_row_reg) + RXW'(2)) < RXW'(rows_used);

    assign edges.first_col = (col_cnt_reg == '0);
    assign edges.last_col  = (CNT_CW'(col_cnt_reg) + CNT_CW'(1)) == cols_used;

    lifegen_cell_unit #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_cell (
        .above  (above_reg),
        .center (cur_reg),
        .below  (below_reg),
        .col    (col_cnt_reg),
        .edges  (edges),
        .alive  (cell_alive)
    );

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        col_idx_next = col_idx_reg;
        row_idx_next = row_idx_reg;
        val_next     = val_reg;
        gen_row_next = gen_row_reg;
        col_cnt_next = col_cnt_reg;
        clr_cnt_next = clr_cnt_reg;
        above_next   = above_reg;
        cur_next     = cur_reg;
        below_next   = below_reg;
        new_next     = new_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = rd_data_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + ROW_W'(1);
                if (clr_cnt_reg == ROW_W'(MAX_ROWS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = item.command;
                    col_idx_next = COL_W'(item.column);
                    row_idx_next = ROW_W'(item.row);
                    val_next     = item.cell_value;
                    result_next.cell_state        = 1'b0;
                    result_next.completed_command = item.command;
                    unique case (item.command)
                        CMD_WRITE, CMD_READ:
                        begin
                            if (item_inside)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = ROW_W'(item.row);
                                state_next = ST_ACCESS;
                            end
                            else
                                strobe_next = 1'b1;
                        end
                        CMD_STEP:
                        begin
                            if (window_empty)
                                strobe_next = 1'b1;
                            else
                            begin
                                rd_en        = 1'b1;
                                rd_addr      = '0;
                                gen_row_next = '0;
                                state_next   = ST_PRIME;
                            end
                        end
                        default:
                            strobe_next = 1'b1;
                    endcase
                end
            end
            ST_ACCESS:
            begin
                if (cmd_reg == CMD_WRITE)
                begin
                    wr_en                = 1'b1;
                    wr_addr              = row_idx_reg;
                    wr_data[col_idx_reg] = val_reg;
                end
                else
                    result_next.cell_state = rd_data_reg[col_idx_reg];
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_PRIME:
            begin
                above_next = '0;
                cur_next   = rd_data_reg;
                if (below_ok)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ROW_W'(1);
                end
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                below_next   = below_ok ? rd_data_reg : '0;
                new_next     = cur_reg;
                col_cnt_next = '0;
                state_next   = ST_CELL;
            end
            ST_CELL:
            begin
                new_next[col_cnt_reg] = cell_alive;
                col_cnt_next          = col_cnt_reg + COL_W'(1);
                if (edges.last_col)
                    state_next = ST_WB;
            end
            ST_WB:
            begin
                wr_en      = 1'b1;
                wr_addr    = gen_row_reg;
                wr_data    = new_reg;
                above_next = cur_reg;
                cur_next   = below_reg;
                if (below2_ok)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ROW_W'(RXW'(gen_row_reg) + RXW'(2));
                end
                if (below_ok)
                begin
                    gen_row_next = gen_row_reg + ROW_W'(1);
                    state_next   = ST_FETCH;
                end
                else
                begin
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
            width_reg   <= SIZE_RESET;
            height_reg  <= SIZE_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            strobe_reg  <= strobe_next;
            if (cfg_write)
            begin
                unique case (paddr[2])
                    REG_GRID_WIDTH:  width_reg  <= pwdata[SIZE_W-1:0];
                    REG_GRID_HEIGHT: height_reg <= pwdata[SIZE_W-1:0];
                    default:         width_reg  <= width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        col_idx_reg <= col_idx_next;
        row_idx_reg <= row_idx_next;
        val_reg     <= val_next;
        gen_row_reg <= gen_row_next;
        col_cnt_reg <= col_cnt_next;
        above_reg   <= above_next;
        cur_reg     <= cur_next;
        below_reg   <= below_next;
        new_reg     <= new_next;
        result_reg  <= result_next;
    end

    // one row per entry, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            grid_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= grid_mem[rd_addr];
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_GRID_WIDTH:  prdata = DATA_W'(width_reg);
            REG_GRID_HEIGHT: prdata = DATA_W'(height_reg);
            default:         prdata = '0;
        endcase
    end

    a_accept_gives_busy_or_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || strobe))
        else $error("accepted item neither busy nor answered");

    a_state_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (!result.cell_state || result.completed_command == CMD_READ))
        else $error("cell state set on a non-read result");

    a_cell_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CELL) |-> (CNT_CW'(col_cnt_reg) < cols_used))
        else $error("generation column outside window");

    a_writeback_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |-> (CNT_RW'(gen_row_reg) < rows_used))
        else $error("generation row outside window");

    a_step_ends_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WB) && !below_ok) |=> (strobe && !busy))
        else $error("generation finished without result");

endmodule
